// File: rtl/core/velm_pkg.sv
package velm_pkg;

  localparam logic [1:0] OP_EXIT       = 2'd0;
  localparam logic [1:0] OP_ENTRY      = 2'd1;
  localparam logic [1:0] OP_READ_STATS = 2'd2;
  localparam logic [1:0] OP_READ_HIST  = 2'd3;

  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_STATS = 2'd1;
  localparam logic [1:0] KIND_HIST  = 2'd2;

  localparam logic [63:0] ALL_ONES = '1;

  // Number of finite histogram bounds; a duration above all of them
  // lands in the last bin.
  localparam int NUM_BOUNDS = 13;

  // us <= b is the same as ns < (b + 1) * 1000, so no divide is needed.
  localparam logic [63:0] BIN_LIMIT_NS [NUM_BOUNDS] = '{
    64'd2000, 64'd6000, 64'd11000, 64'd51000, 64'd101000, 64'd501000,
    64'd1001000, 64'd5001000, 64'd10001000, 64'd50001000, 64'd100001000,
    64'd500001000, 64'd1000001000
  };

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  vcpu;
    logic [7:0]  reason;
    logic [63:0] time_ns;
    logic [21:0] process_id;
    logic [4:0]  bin;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_vcpu;
    logic [7:0]  out_reason;
    logic [63:0] out_time;
    logic [21:0] out_pid;
    logic [63:0] duration;
    logic        seen;
    logic [63:0] count;
    logic [63:0] total;
    logic [63:0] longest;
    logic [63:0] shortest;
  } rsp_word_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  reason;
    logic [63:0] stamp;
  } pend_entry_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] count;
    logic [63:0] total;
    logic [63:0] longest;
    logic [63:0] shortest;
  } rsn_entry_t;

  // Returns the first bound index the duration falls under, NUM_BOUNDS if none.
  function automatic logic [3:0] pick_bound(input logic [63:0] d);
    logic [3:0] r;
    r = 4'(NUM_BOUNDS);
    for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
      if (d < BIN_LIMIT_NS[i]) r = 4'(i);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/vm_exit_latency_monitor.sv
// Path from accept to result word: a read loads it in S_RD; an entry with a
// pending exit goes on through S_ENT and S_WB (pending table read, then reason
// table read at the pending reason). Exits and unmatched entries give no result.
// Flow: one word at a time; the next word is taken once the sequencer is back in
// S_IDLE, which is delayed while a result word is stalled.
// Reset: synchronous, then a clearing pass over both tables in S_CLR, req_stall high.
module vm_exit_latency_monitor #(
  parameter int VCPU_COUNT   = 256,
  parameter int REASON_COUNT = 256,
  parameter int HIST_BINS    = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  velm_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output velm_pkg::rsp_word_t rsp
);
  import velm_pkg::*;

  localparam int VW        = (VCPU_COUNT > 1) ? $clog2(VCPU_COUNT) : 1;
  localparam int RW        = (REASON_COUNT > 1) ? $clog2(REASON_COUNT) : 1;
  localparam int HW        = $clog2(HIST_BINS);
  localparam int CLR_DEPTH = (VCPU_COUNT > REASON_COUNT) ? VCPU_COUNT : REASON_COUNT;
  localparam int CW        = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  // Sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;  // clearing pass after reset
  localparam logic [2:0] S_IDLE = 3'd1;  // waiting for a word
  localparam logic [2:0] S_RD   = 3'd2;  // first read data back
  localparam logic [2:0] S_ENT  = 3'd3;  // entry: reason stats back
  localparam logic [2:0] S_WB   = 3'd4;  // entry: histogram + event out

  logic [2:0]  state, state_next;
  logic [CW-1:0] clr_idx;

  // Per-vCPU pending table and per-reason statistics table
  pend_entry_t pend_mem [VCPU_COUNT];
  rsn_entry_t  rsn_mem  [REASON_COUNT];
  logic [63:0] hist [HIST_BINS];

  req_word_t   cur;       // word in flight
  pend_entry_t pend_rd;   // registered pending read data
  rsn_entry_t  rsn_rd;    // registered reason read data
  logic [63:0] dur;
  logic [HW-1:0] bin_q;

  logic        accept;
  logic        out_free;
  logic        vcpu_ok, rsn_ok, prsn_ok, hbin_ok;
  logic        entry_go;
  logic        stats_upd;

  logic        pend_we;
  logic [VW-1:0] pend_waddr;
  pend_entry_t pend_wdata;
  logic        rsn_we;
  logic [RW-1:0] rsn_waddr;
  rsn_entry_t  rsn_wdata;
  logic        rsn_re;
  logic [RW-1:0] rsn_raddr;

  logic [HW-1:0] hist_raddr;
  logic [63:0] hist_rd;
  logic        hist_inc;
  logic [3:0]  bound_idx;
  logic [HW-1:0] bin_next;

  logic        rsp_load;
  rsp_word_t   rsp_next;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign vcpu_ok   = (32'(cur.vcpu) < VCPU_COUNT);
  assign rsn_ok    = (32'(cur.reason) < REASON_COUNT);
  assign prsn_ok   = (32'(pend_rd.reason) < REASON_COUNT);
  assign hbin_ok   = (32'(cur.bin) < HIST_BINS);
  assign entry_go  = (cur.operation == OP_ENTRY) && vcpu_ok && pend_rd.valid;
  assign stats_upd = prsn_ok && rsn_rd.valid;

  // Reason table is read for the word itself on accept, or at the pending
  // reason once the pending entry is back.
  assign rsn_re    = accept || ((state == S_RD) && entry_go);
  assign rsn_raddr = (state == S_IDLE) ? RW'(req.reason) : RW'(pend_rd.reason);

  // Single histogram read port: bin to bump, or bin asked for.
  assign hist_raddr = (state == S_WB) ? bin_q : HW'(cur.bin);
  assign hist_rd    = hist[hist_raddr];

  assign bound_idx = pick_bound(dur);
  assign bin_next  = (bound_idx == 4'(NUM_BOUNDS)) ? HW'(HIST_BINS - 1) : HW'(bound_idx);

  // Sequencer and memory write control
  always_comb begin
    state_next = state;
    pend_we    = 1'b0;
    pend_waddr = VW'(cur.vcpu);
    pend_wdata = pend_rd;
    rsn_we     = 1'b0;
    rsn_waddr  = RW'(cur.reason);
    rsn_wdata  = rsn_rd;
    rsp_load   = 1'b0;
    rsp_next   = '0;
    hist_inc   = 1'b0;
    unique case (state)
      S_CLR: begin
        pend_we    = (32'(clr_idx) < VCPU_COUNT);
        pend_waddr = VW'(clr_idx);
        pend_wdata = '0;
        rsn_we     = (32'(clr_idx) < REASON_COUNT);
        rsn_waddr  = RW'(clr_idx);
        rsn_wdata  = '0;
        if (32'(clr_idx) == CLR_DEPTH - 1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_RD;
      end
      S_RD: begin
        unique case (cur.operation)
          OP_EXIT: begin
            pend_we    = vcpu_ok;
            pend_wdata = '{valid: 1'b1, reason: cur.reason, stamp: cur.time_ns};
            rsn_we     = vcpu_ok && rsn_ok;
            if (rsn_rd.valid) begin
              rsn_wdata.count = rsn_rd.count + 64'd1;
            end else begin
              rsn_wdata = '{valid: 1'b1, count: 64'd1, total: 64'd0,
                            longest: 64'd0, shortest: ALL_ONES};
            end
            state_next = S_IDLE;
          end
          OP_ENTRY: begin
            pend_we          = entry_go;
            pend_wdata.valid = 1'b0;
            state_next       = entry_go ? S_ENT : S_IDLE;
          end
          OP_READ_STATS: begin
            rsp_next.kind       = KIND_STATS;
            rsp_next.out_reason = cur.reason;
            if (rsn_ok && rsn_rd.valid) begin
              rsp_next.seen     = 1'b1;
              rsp_next.count    = rsn_rd.count;
              rsp_next.total    = rsn_rd.total;
              rsp_next.longest  = rsn_rd.longest;
              rsp_next.shortest = rsn_rd.shortest;
            end else begin
              rsp_next.shortest = ALL_ONES;
            end
            if (out_free) begin
              rsp_load   = 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_READ_HIST: begin
            rsp_next.kind  = KIND_HIST;
            rsp_next.count = hbin_ok ? hist_rd : 64'd0;
            if (out_free) begin
              rsp_load   = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_ENT: begin
        // Fold the duration into the pending reason's statistics.
        rsn_we            = stats_upd;
        rsn_waddr         = RW'(pend_rd.reason);
        rsn_wdata.total   = rsn_rd.total + dur;
        rsn_wdata.longest = (dur > rsn_rd.longest) ? dur : rsn_rd.longest;
        rsn_wdata.shortest = (dur < rsn_rd.shortest) ? dur : rsn_rd.shortest;
        state_next        = S_WB;
      end
      S_WB: begin
        rsp_next.kind       = KIND_EVENT;
        rsp_next.out_vcpu   = cur.vcpu;
        rsp_next.out_reason = pend_rd.reason;
        rsp_next.out_time   = cur.time_ns;
        rsp_next.out_pid    = cur.process_id;
        rsp_next.duration   = dur;
        if (out_free) begin
          rsp_load   = 1'b1;
          hist_inc   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_idx <= clr_idx + CW'(1);
      if (rsp_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // Histogram counters, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_BINS; i++) hist[i] <= '0;
    end else if (hist_inc) begin
      hist[bin_q] <= hist_rd + 64'd1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) cur <= req;
    if (rsp_load) rsp <= rsp_next;
    if (state == S_RD) dur <= cur.time_ns - pend_rd.stamp;
    if (state == S_ENT) bin_q <= bin_next;
  end

  // Pending table: one write, one read port, registered read
  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
    if (accept) pend_rd <= pend_mem[VW'(req.vcpu)];
  end

  // Reason statistics table: one write, one read port, registered read
  always_ff @(posedge clk) begin
    if (rsn_we) rsn_mem[rsn_waddr] <= rsn_wdata;
    if (rsn_re) rsn_rd <= rsn_mem[rsn_raddr];
  end

endmodule

// File: rtl/core/velm_checker.sv
module velm_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input velm_pkg::req_word_t req,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input velm_pkg::rsp_word_t rsp
);
  import velm_pkg::*;

  // A stalled result word stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word dropped or changed while stalled");

  // No result straight out of reset.
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Latency events carry no statistics.
  a_event_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == KIND_EVENT |->
      !rsp.seen && rsp.count == 64'd0 && rsp.total == 64'd0 && rsp.shortest == 64'd0)
    else $error("latency event with statistics fields set");

  // Unseen reason reads as empty with shortest all ones.
  a_unseen_stats: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == KIND_STATS && !rsp.seen |->
      rsp.count == 64'd0 && rsp.total == 64'd0 && rsp.longest == 64'd0 &&
      rsp.shortest == ALL_ONES)
    else $error("unseen reason statistics not empty");

  // Histogram reads carry only a count.
  a_hist_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == KIND_HIST |->
      rsp.duration == 64'd0 && rsp.out_vcpu == 8'd0 && !rsp.seen)
    else $error("histogram word with event fields set");

endmodule

bind vm_exit_latency_monitor velm_checker u_velm_checker (.*);

// File: dv/tb_vm_exit_latency_monitor.sv
`timescale 1ns / 1ps

module tb_vm_exit_latency_monitor;
  import velm_pkg::*;

  localparam int HIST_BINS  = 20;
  localparam int VCPUS      = 256;
  localparam int REASONS    = 256;
  localparam int RUN_LIMIT  = 600000;
  localparam int LONG_HOLD  = 400;
  localparam int PRINT_CAP  = 40;

  // Histogram edges in microseconds: a duration lands in the first bin whose
  // edge it does not exceed, otherwise in the overflow bin.
  localparam longint unsigned BIN_EDGE_US [13] = '{
    1, 5, 10, 50, 100, 500, 1000, 5000, 10000, 50000, 100000, 500000, 1000000
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  vm_exit_latency_monitor u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------
  req_word_t cmd_q [$];        // words waiting for the driver
  rsp_word_t report_q [$];     // events and read-backs the block owes us
  int        words_issued = 0;
  int        words_taken  = 0;
  logic      req_taken    = 1'b0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_asked  = 0;
  int        hold_served = 0;
  int        hold_left   = 0;
  int        cycles      = 0;
  int        mismatches  = 0;

  // Latency accounting state, mirrors the block's tables.
  bit          pend_on    [VCPUS];
  logic [63:0] pend_stamp [VCPUS];
  logic [7:0]  pend_cause [VCPUS];
  bit          rsn_on     [REASONS];
  logic [63:0] rsn_count  [REASONS];
  logic [63:0] rsn_total  [REASONS];
  logic [63:0] rsn_long   [REASONS];
  logic [63:0] rsn_short  [REASONS];
  logic [63:0] hist_tally [HIST_BINS];

  // Stimulus-side view of open exits, in issue order (= accept order).
  bit          open_flag [VCPUS];
  logic [63:0] open_exit_time [VCPUS];
  int          open_vcpus [$];

  function automatic int bin_of(input logic [63:0] ns);
    logic [63:0] us;
    us = ns / 64'd1000;
    for (int i = 0; i < 13; i++) begin
      if (us <= BIN_EDGE_US[i]) return i;
    end
    return HIST_BINS - 1;
  endfunction

  // Applies one accepted word to the tables and queues the report it owes.
  // vcpu and reason are 8 bits wide, so with 256-entry tables they are
  // always in range; every reason that has had an exit therefore has stats.
  task automatic account_word(input req_word_t w);
    rsp_word_t   r;
    logic [63:0] dur;
    logic [7:0]  pr;
    int          vc;
    int          rs;
    r  = '0;
    vc = int'(w.vcpu);
    rs = int'(w.reason);
    case (w.operation)
      OP_EXIT: begin
        // A second exit simply overwrites the pending stamp and reason.
        pend_on[vc]    = 1'b1;
        pend_stamp[vc] = w.time_ns;
        pend_cause[vc] = w.reason;
        if (rsn_on[rs]) begin
          rsn_count[rs] = rsn_count[rs] + 64'd1;
        end else begin
          rsn_on[rs]    = 1'b1;
          rsn_count[rs] = 64'd1;
          rsn_total[rs] = '0;
          rsn_long[rs]  = '0;
          rsn_short[rs] = ALL_ONES;
        end
      end
      OP_ENTRY: begin
        // Entry with nothing pending is dropped silently.
        if (pend_on[vc]) begin
          dur = w.time_ns - pend_stamp[vc];
          pr  = pend_cause[vc];
          if (rsn_on[pr]) begin
            rsn_total[pr] = rsn_total[pr] + dur;
            if (dur > rsn_long[pr]) rsn_long[pr] = dur;
            if (dur < rsn_short[pr]) rsn_short[pr] = dur;
          end
          hist_tally[bin_of(dur)] = hist_tally[bin_of(dur)] + 64'd1;
          pend_on[vc]  = 1'b0;
          r.kind       = KIND_EVENT;
          r.out_vcpu   = w.vcpu;
          r.out_reason = pr;
          r.out_time   = w.time_ns;
          r.out_pid    = w.process_id;
          r.duration   = dur;
          report_q.push_back(r);
        end
      end
      OP_READ_STATS: begin
        r.kind       = KIND_STATS;
        r.out_reason = w.reason;
        if (rsn_on[rs]) begin
          r.seen     = 1'b1;
          r.count    = rsn_count[rs];
          r.total    = rsn_total[rs];
          r.longest  = rsn_long[rs];
          r.shortest = rsn_short[rs];
        end else begin
          r.shortest = ALL_ONES;
        end
        report_q.push_back(r);
      end
      default: begin
        r.kind = KIND_HIST;
        if (w.bin < HIST_BINS) r.count = hist_tally[w.bin];
        report_q.push_back(r);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH cycle %0d: %s", cycles, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // ---------------------------------------------------------------------
  // Driver: one word at a time from cmd_q, changes on the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req       <= cmd_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Request side sampling: accepted words feed the accounting model.
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        account_word(req);
        words_taken <= words_taken + 1;
      end
    end
  end

  // Long receiver hold-off, counted here so it runs independent of stimulus.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_left   <= LONG_HOLD;
      hold_served <= hold_served + 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each accepted result against the oldest report owed
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (report_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", rsp.kind));
      end else begin
        want = report_q.pop_front();
        check_field("kind", 64'(rsp.kind), 64'(want.kind));
        check_field("out_vcpu", 64'(rsp.out_vcpu), 64'(want.out_vcpu));
        check_field("out_reason", 64'(rsp.out_reason), 64'(want.out_reason));
        check_field("out_time", rsp.out_time, want.out_time);
        check_field("out_pid", 64'(rsp.out_pid), 64'(want.out_pid));
        check_field("duration", rsp.duration, want.duration);
        check_field("seen", 64'(rsp.seen), 64'(want.seen));
        check_field("count", rsp.count, want.count);
        check_field("total", rsp.total, want.total);
        check_field("longest", rsp.longest, want.longest);
        check_field("shortest", rsp.shortest, want.shortest);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Half the durations cluster around the histogram edges, both sides of each.
  function automatic logic [63:0] rand_dur();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0:       return 64'($urandom_range(999));
      1:       return rand64();
      2:       return ALL_ONES - 64'($urandom_range(3));
      3, 4:    return 64'($urandom_range(2000000000));
      default: return 64'(BIN_EDGE_US[$urandom_range(12)]) * 64'd1000 - 64'd1000
                      + 64'($urandom_range(2000));
    endcase
  endfunction

  task automatic push_word(input logic [1:0] op, input int vc, input int rs,
                           input logic [63:0] stamp, input logic [21:0] pid,
                           input int bn);
    req_word_t w;
    w.operation  = op;
    w.vcpu       = 8'(vc);
    w.reason     = 8'(rs);
    w.time_ns    = stamp;
    w.process_id = pid;
    w.bin        = 5'(bn);
    if (op == OP_EXIT) begin
      if (!open_flag[vc]) open_vcpus.push_back(vc);
      open_flag[vc]      = 1'b1;
      open_exit_time[vc] = stamp;
    end else if (op == OP_ENTRY && open_flag[vc]) begin
      open_flag[vc] = 1'b0;
      foreach (open_vcpus[i]) begin
        if (open_vcpus[i] == vc) begin
          open_vcpus.delete(i);
          break;
        end
      end
    end
    cmd_q.push_back(w);
    words_issued++;
  endtask

  // Mostly matched exit/entry pairs on a small vCPU and reason pool so that
  // stats accumulate; entries with nothing pending are noise and not counted.
  task automatic push_random_items(input int target);
    int done;
    int sel;
    int vc;
    int rs;
    done = 0;
    while (done < target) begin
      sel = $urandom_range(99);
      if (sel < 38) begin
        vc = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15);
        rs = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7);
        push_word(OP_EXIT, vc, rs, rand64(), 22'($urandom), $urandom_range(31));
        done++;
      end else if (sel < 75 && open_vcpus.size() != 0) begin
        vc = open_vcpus[$urandom_range(open_vcpus.size() - 1)];
        push_word(OP_ENTRY, vc, $urandom_range(255), open_exit_time[vc] + rand_dur(),
                  22'($urandom), $urandom_range(31));
        done++;
      end else if (sel < 80) begin
        vc = $urandom_range(255);
        if (open_flag[vc]) done++;
        push_word(OP_ENTRY, vc, $urandom_range(255), rand64(), 22'($urandom),
                  $urandom_range(31));
      end else if (sel < 92) begin
        rs = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7);
        push_word(OP_READ_STATS, $urandom_range(255), rs, rand64(), 22'($urandom),
                  $urandom_range(31));
        done++;
      end else begin
        push_word(OP_READ_HIST, $urandom_range(255), $urandom_range(255), rand64(),
                  22'($urandom), $urandom_range(31));
        done++;
      end
    end
  endtask

  // Sender pause: nothing left to send and every owed report delivered.
  task automatic wait_drained();
    do @(posedge clk);
    while (words_taken != words_issued || report_q.size() != 0);
  endtask

  initial begin
    foreach (hist_tally[i]) hist_tally[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Phase 1: sender mostly busy, receiver mostly stalled.
    send_idle_pct = 16;
    recv_idle_pct = 83;

    // Directed words
    push_word(OP_READ_STATS, 0, 0, '0, '0, 0);           // reason never seen
    push_word(OP_READ_HIST, 0, 0, '0, '0, 0);
    push_word(OP_READ_HIST, 0, 0, '0, '0, 31);           // bin past the end
    push_word(OP_ENTRY, 5, 0, 64'd77, '0, 0);            // nothing pending
    push_word(OP_EXIT, 0, 0, '0, '0, 0);
    push_word(OP_ENTRY, 0, 0, '0, 22'h3FFFFF, 0);        // zero duration
    push_word(OP_EXIT, 255, 255, ALL_ONES, 22'h3FFFFF, 19);
    push_word(OP_ENTRY, 255, 255, ALL_ONES - 64'd1, '0, 31); // wraps to all ones
    push_word(OP_EXIT, 1, 7, 64'd1000, '0, 0);
    push_word(OP_EXIT, 1, 9, 64'd5000, '0, 0);           // overwrites pending
    push_word(OP_ENTRY, 1, 0, 64'd1005000, 22'h15555, 0); // exactly 1000 us
    push_word(OP_READ_STATS, 0, 7, '0, '0, 0);           // seen, no durations
    push_word(OP_READ_STATS, 0, 9, '0, '0, 0);
    push_word(OP_EXIT, 2, 9, 64'h8000_0000_0000_0000, '0, 0);
    push_word(OP_ENTRY, 2, 0, 64'h8000_0000_0000_0000 + 64'd1000001000, '0, 0);
    push_word(OP_EXIT, 3, 9, 64'd123, '0, 0);
    push_word(OP_ENTRY, 3, 0, 64'd123 + 64'd1999, '0, 0); // 1 us, first bin
    push_word(OP_READ_STATS, 0, 9, '0, '0, 0);
    push_word(OP_READ_STATS, 0, 255, '0, '0, 0);
    push_word(OP_READ_HIST, 0, 0, '0, '0, 6);
    push_word(OP_READ_HIST, 0, 0, '0, '0, 19);
    push_word(OP_READ_HIST, 0, 0, '0, '0, 20);
    push_word(OP_READ_HIST, 0, 0, '0, '0, 0);

    push_random_items(360);
    wait_drained();

    // Phase 2: roles swapped.
    send_idle_pct = 83;
    recv_idle_pct = 16;
    push_random_items(360);
    wait_drained();

    // Phase 3: full rate both ways, with one long receiver hold-off while
    // the sender keeps offering words until the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_items(180);
    hold_asked++;
    repeat (2) @(posedge clk);
    push_random_items(40);
    push_random_items(180);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/velm_pkg.sv
rtl/core/vm_exit_latency_monitor.sv
rtl/core/velm_checker.sv
dv/tb_vm_exit_latency_monitor.sv
